/* rtl/ssd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Shared constants, request codes, command and status types and the segment
// decoder for the multiplexed display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int NUM_POSITIONS_DEF = 8;
    localparam int STORE_DEPTH       = 8;
    localparam int POS_W             = 3;
    localparam int DIGIT_W           = 4;
    localparam int NUM_W             = 16;
    localparam int WORK_W            = 14;
    localparam int IDX_W             = 2;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_SCAN  = 2'd2;

    localparam logic [2:0] LATCH_POS = 3'd6;
    localparam logic [2:0] LATCH_SEG = 3'd7;

    localparam logic [NUM_W-1:0] NUM_LIMIT = 16'd10000;

    // Reciprocal of ten, exact for every 16-bit value.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic load_start;
        logic load_step;
        logic clear;
        logic scan_capture;
        logic seg_phase;
    } t_dp_cmd;

    typedef struct packed {
        logic num_ok;
        logic digit_last;
    } t_dp_status;

    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'hc0;
            4'd1:    pat = 8'hf9;
            4'd2:    pat = 8'ha4;
            4'd3:    pat = 8'hb0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hf8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = 8'hff;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/ssd_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one display request.
// ----------------------------------------------------------------------------
interface ssd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] number_value;

    modport source (output valid, output req_type, output number_value, input ready);
    modport sink   (input valid, input req_type, input number_value, output ready);
endinterface

/* rtl/ssd_wr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latch write channel interface
// Valid/ready channel that carries one latch write on the shared byte bus.
// ----------------------------------------------------------------------------
interface ssd_wr_if;
    logic       valid;
    logic       ready;
    logic [2:0] latch_select;
    logic [7:0] bus_data;
    logic       last_write;

    modport source (output valid, output latch_select, output bus_data, output last_write,
                    input ready);
    modport sink   (input valid, input latch_select, input bus_data, input last_write,
                    output ready);
endinterface

/* rtl/ssd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver datapath
// Digit store, digit-serial decimal split, scan position and latch write bytes.
// ----------------------------------------------------------------------------
module ssd_datapath #(
    parameter int NUM_POSITIONS = ssd_pkg::NUM_POSITIONS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssd_pkg::t_dp_cmd             i_cmd,
    input  logic [ssd_pkg::NUM_W-1:0]    i_number,
    output ssd_pkg::t_dp_status          o_status,
    output logic [2:0]                   o_latch_select,
    output logic [7:0]                   o_bus_data,
    output logic                         o_last_write
);

    localparam logic [ssd_pkg::POS_W-1:0] LAST_POS = ssd_pkg::POS_W'(NUM_POSITIONS - 1);

    logic [ssd_pkg::DIGIT_W-1:0] r_store [ssd_pkg::STORE_DEPTH];
    logic [ssd_pkg::WORK_W-1:0]  r_num;
    logic [ssd_pkg::IDX_W-1:0]   r_idx;
    logic [ssd_pkg::POS_W-1:0]   r_pos;
    logic [7:0]                  r_sel_byte;
    logic [7:0]                  r_seg_byte;

    logic [29:0]                 n_prod;
    logic [ssd_pkg::WORK_W-1:0]  n_quot;
    logic [ssd_pkg::WORK_W-1:0]  n_times_ten;
    logic [ssd_pkg::WORK_W-1:0]  n_rem;
    logic [ssd_pkg::POS_W-1:0]   n_pos;

    always_comb begin
        n_prod      = 30'(r_num) * 30'(ssd_pkg::RECIP_TEN);
        n_quot      = ssd_pkg::WORK_W'(n_prod[29:ssd_pkg::RECIP_SHIFT]);
        n_times_ten = ssd_pkg::WORK_W'({n_quot, 3'b000}) + ssd_pkg::WORK_W'({n_quot, 1'b0});
        n_rem       = r_num - n_times_ten;
        n_pos       = (r_pos >= LAST_POS) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ssd_pkg::STORE_DEPTH; k++) begin
                r_store[k] <= '0;
            end
            r_pos <= '0;
        end else begin
            if (i_cmd.clear) begin
                for (int k = 0; k < ssd_pkg::STORE_DEPTH; k++) begin
                    r_store[k] <= '0;
                end
            end else if (i_cmd.load_step) begin
                r_store[{1'b0, r_idx}] <= n_rem[ssd_pkg::DIGIT_W-1:0];
            end
            if (i_cmd.scan_capture) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_num <= i_number[ssd_pkg::WORK_W-1:0];
            r_idx <= '0;
        end else if (i_cmd.load_step) begin
            r_num <= n_quot;
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan_capture) begin
            r_sel_byte <= 8'h80 >> r_pos;
            r_seg_byte <= ssd_pkg::seg_pattern(r_store[r_pos]);
        end
    end

    assign o_status.num_ok     = (i_number < ssd_pkg::NUM_LIMIT);
    assign o_status.digit_last = (n_quot == '0);

    assign o_latch_select = i_cmd.seg_phase ? ssd_pkg::LATCH_SEG : ssd_pkg::LATCH_POS;
    assign o_bus_data     = i_cmd.seg_phase ? r_seg_byte : r_sel_byte;
    assign o_last_write   = i_cmd.seg_phase;

endmodule

/* rtl/ssd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver controller
// Request decoding, load sequencing and the two-write scan handshake.
// ----------------------------------------------------------------------------
module ssd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_req_type,
    input  logic                 i_out_ready,
    input  ssd_pkg::t_dp_status  i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output ssd_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SEL,
        S_SEG
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_seg_phase;
    logic   w_accept;
    logic   w_out_accept;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_accept = r_out_valid && i_out_ready;

    always_comb begin
        o_cmd              = '0;
        o_cmd.seg_phase    = r_seg_phase;
        o_cmd.load_start   = w_accept && (i_req_type == ssd_pkg::REQ_LOAD) && i_status.num_ok;
        o_cmd.clear        = w_accept && (i_req_type == ssd_pkg::REQ_CLEAR);
        o_cmd.scan_capture = w_accept && (i_req_type == ssd_pkg::REQ_SCAN);
        o_cmd.load_step    = (r_state == S_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_seg_phase <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load_start) begin
                        r_state <= S_LOAD;
                    end else if (o_cmd.scan_capture) begin
                        r_state     <= S_SEL;
                        r_out_valid <= 1'b1;
                        r_seg_phase <= 1'b0;
                    end
                end
                S_LOAD: begin
                    if (i_status.digit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SEL: begin
                    if (w_out_accept) begin
                        r_state     <= S_SEG;
                        r_seg_phase <= 1'b1;
                    end
                end
                S_SEG: begin
                    if (w_out_accept) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_seg_phase <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_accept_while_writing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_out_valid)
        else $error("request accepted while a latch write is pending");

    a_seg_follows_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_accept && !r_seg_phase) |=> (r_out_valid && r_seg_phase))
        else $error("segment write did not follow the select write");

    a_scan_starts_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_capture |=> (r_out_valid && !r_seg_phase))
        else $error("scan request did not start with the select write");

    a_load_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && i_status.digit_last) |=> o_in_ready)
        else $error("load sequence did not return to idle");

endmodule

/* rtl/seven_segment_scan_driver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Drives a multiplexed common-anode seven-segment display through a position
// latch and a segment latch on a shared byte bus.
//
//   Channel  Direction  Payload                              One request
//   i_req    in         req_type, number_value               load, clear, scan
//   o_wr     out        latch_select, bus_data, last_write   one latch write
//
// A clear request completes when it is accepted. A load is accepted and then
// runs the divide-by-ten step loop, one step per decimal digit.
// A scan request is accepted and then gives two latch writes, select then segment,
// one per cycle when the sink is ready.
// Synchronous active-low reset zeroes the digit store and the scan position.
// Requests are held off while a load runs or a latch write is pending.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
    parameter int NUM_POSITIONS = ssd_pkg::NUM_POSITIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_req_if.sink   i_req,
    ssd_wr_if.source  o_wr
);

    ssd_pkg::t_dp_cmd    w_cmd;
    ssd_pkg::t_dp_status w_status;

    ssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_out_ready (o_wr.ready),
        .i_status    (w_status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_wr.valid),
        .o_cmd       (w_cmd)
    );

    ssd_datapath #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_number       (i_req.number_value),
        .o_status       (w_status),
        .o_latch_select (o_wr.latch_select),
        .o_bus_data     (o_wr.bus_data),
        .o_last_write   (o_wr.last_write)
    );

endmodule
